>>> rtl/whist_pkg.sv
// Package for the weighted cumulative histogram.
// Holds the command codes, fixed widths and the structs shared by the modules.
// No dependencies.
`default_nettype none
package whist_pkg;
	localparam logic [1:0] CMD_ADD    = 2'd0;
	localparam logic [1:0] CMD_REWIND = 2'd1;
	localparam logic [1:0] CMD_GET    = 2'd2;

	localparam int CNT_W  = 32;
	localparam int ERR_W  = 48;
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// one bin entry as written to the store
	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [ERR_W-1:0] err;
	} whist_entry_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} whist_div_stat_t;
endpackage
`default_nettype wire

>>> rtl/weighted_cumulative_histogram.sv
// Top level of the weighted cumulative histogram: sequencer, counters, output register.
// Depends on whist_pkg, whist_div and whist_store.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------
//  input    | in_valid / in_stall | command, diff_value, error_value
//  output   | out_valid/out_stall | fraction, equity_out, more
//  config   | cfg_we              | cfg_index, cfg_data
//
// After reset the store is cleared, one bin a cycle; no item is taken.
// Rewind, an unused code or an add of a zero difference updates only registers. Any other add
// reads and writes back its bin, first finding the bin on the divider for a non-zero bin step.
// Get next walks the bins up to the cursor, runs two divisions on the shared divider and
// hands over the result; with no positive samples it goes straight to the result.
// A finished result waits in the output register; a new item is taken meanwhile.
`default_nettype none
module weighted_cumulative_histogram import whist_pkg::*; #(
	parameter int BINS = 256
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [1:0]  command,
	input  wire  [31:0] diff_value,
	input  wire  [31:0] error_value,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [16:0] fraction,
	output logic [31:0] equity_out,
	output logic        more,
	input  wire         cfg_we,
	input  wire         cfg_index,
	input  wire  [31:0] cfg_data
);
	localparam int IW = $clog2(BINS);
	localparam int CW = IW + 1;
	localparam int SW = CNT_W + IW + 1;
	localparam logic [IW-1:0] LAST = IW'(BINS - 1);

	localparam logic [3:0] S_CLR  = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_ADIV = 4'd2;
	localparam logic [3:0] S_ARD  = 4'd3;
	localparam logic [3:0] S_AWR  = 4'd4;
	localparam logic [3:0] S_GRD  = 4'd5;
	localparam logic [3:0] S_GDF  = 4'd6;
	localparam logic [3:0] S_GDE  = 4'd7;
	localparam logic [3:0] S_GOUT = 4'd8;

	logic [3:0]        state_q;
	logic [31:0]       bin_step_q;
	logic [7:0]        max_bin_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  pos_q;
	logic [ERR_W-1:0]  err_total_q;
	logic [CW-1:0]     cursor_q;
	logic [IW-1:0]     addr_q;
	logic [IW-1:0]     walk_q;
	logic              issuing_q;
	logic              data_vld_s1;
	logic [ERR_W-1:0]  err_q;
	logic [SW-1:0]     sum_q;
	logic [63:0]       rem_q;
	logic              neg_q;
	logic [16:0]       frac_q;
	logic [31:0]       eq_q;

	logic [IW-1:0]     mb;
	logic [IW-1:0]     walk;
	logic [ERR_W-1:0]  err_in;
	logic              accept;
	logic [31:0]       clamped;
	logic [63:0]       rem_abs;
	logic [16:0]       frac_res;
	logic [31:0]       eq_res;
	logic [CW-1:0]     cursor_nx;
	logic              out_free;

	logic              div_start;
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	whist_div_stat_t   div_stat;
	logic [DIV_NW-1:0] div_quo;

	logic              st_rd_en;
	logic [IW-1:0]     st_rd_addr;
	whist_entry_t      st_rd_data;
	logic              st_wr_en;
	logic [IW-1:0]     st_wr_addr;
	whist_entry_t      st_wr_data;

	// last bin in use and walk limit
	always_comb begin
		mb      = ({24'd0, max_bin_q} > 32'(BINS - 1)) ? LAST : IW'(max_bin_q);
		walk    = (cursor_q > CW'(mb)) ? mb : cursor_q[IW-1:0];
		err_in  = {{(ERR_W - 32){error_value[31]}}, error_value};
		accept  = in_valid && !in_stall;
		clamped = (sum_q > SW'(total_q)) ? total_q : sum_q[CNT_W-1:0];
		rem_abs = rem_q[63] ? (64'd0 - rem_q) : rem_q;
		out_free = !out_valid || !out_stall;
		cursor_nx = (cursor_q <= CW'(mb)) ? (cursor_q + 1'b1) : cursor_q;
	end

	// saturate the quotients
	always_comb begin
		frac_res = (div_quo > 64'd65536) ? 17'h10000 : div_quo[16:0];
		if (!neg_q) begin
			eq_res = (div_quo > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_quo[31:0];
		end else begin
			eq_res = (div_quo > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - div_quo[31:0]);
		end
	end

	// divider requests
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = total_q;
		case (state_q)
			S_IDLE: begin
				div_start = accept && (command == CMD_ADD) && (diff_value != 32'd0) &&
					(bin_step_q != 32'd0);
				div_num   = {32'd0, diff_value};
				div_den   = bin_step_q;
			end
			S_GRD: begin
				div_start = !issuing_q && !data_vld_s1;
				div_num   = {16'd0, clamped, 16'd0};
			end
			S_GDF: begin
				div_start = div_stat.done;
				div_num   = rem_abs;
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// store access
	always_comb begin
		st_rd_en   = 1'b0;
		st_rd_addr = addr_q;
		st_wr_en   = 1'b0;
		st_wr_addr = addr_q;
		st_wr_data = '0;
		case (state_q)
			S_CLR: begin
				st_wr_en = 1'b1;
			end
			S_ARD: begin
				st_rd_en = 1'b1;
			end
			S_AWR: begin
				st_wr_en         = 1'b1;
				st_wr_data.count = (st_rd_data.count == CNT_MAX) ? CNT_MAX :
					(st_rd_data.count + 1'b1);
				st_wr_data.err   = st_rd_data.err + err_q;
			end
			S_GRD: begin
				st_rd_en = issuing_q;
			end
			default: begin
				st_rd_en = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_step_q <= 32'd65536;
			max_bin_q  <= 8'd255;
		end else if (cfg_we) begin
			if (cfg_index) begin
				max_bin_q <= cfg_data[7:0];
			end else begin
				bin_step_q <= cfg_data;
			end
		end
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			total_q     <= '0;
			pos_q       <= '0;
			err_total_q <= '0;
			cursor_q    <= '0;
			addr_q      <= '0;
			issuing_q   <= 1'b0;
			data_vld_s1 <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			data_vld_s1 <= (state_q == S_GRD) && issuing_q;
			if (out_valid && !out_stall && state_q != S_GOUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					if (addr_q == LAST) begin
						state_q <= S_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (command)
							CMD_ADD: begin
								total_q <= (total_q == CNT_MAX) ? CNT_MAX : (total_q + 1'b1);
								if (diff_value != 32'd0) begin
									pos_q       <= (pos_q == CNT_MAX) ? CNT_MAX : (pos_q + 1'b1);
									err_total_q <= err_total_q + err_in;
									if (bin_step_q == 32'd0) begin
										addr_q  <= mb;
										state_q <= S_ARD;
									end else begin
										state_q <= S_ADIV;
									end
								end
							end
							CMD_REWIND: begin
								cursor_q <= '0;
							end
							CMD_GET: begin
								if (pos_q == '0 || total_q == '0) begin
									state_q <= S_GOUT;
								end else begin
									addr_q    <= '0;
									issuing_q <= 1'b1;
									state_q   <= S_GRD;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_ADIV: begin
					if (div_stat.done) begin
						addr_q  <= (div_quo > DIV_NW'(mb)) ? mb : div_quo[IW-1:0];
						state_q <= S_ARD;
					end
				end
				S_ARD: begin
					state_q <= S_AWR;
				end
				S_AWR: begin
					state_q <= S_IDLE;
				end
				S_GRD: begin
					if (issuing_q) begin
						if (addr_q == walk_q) begin
							issuing_q <= 1'b0;
						end else begin
							addr_q <= addr_q + 1'b1;
						end
					end
					if (!issuing_q && !data_vld_s1) begin
						state_q <= S_GDF;
					end
				end
				S_GDF: begin
					if (div_stat.done) begin
						state_q <= S_GDE;
					end
				end
				S_GDE: begin
					if (div_stat.done) begin
						state_q <= S_GOUT;
					end
				end
				S_GOUT: begin
					if (out_free) begin
						out_valid <= 1'b1;
						cursor_q  <= cursor_nx;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// item payload, walk sums and results
	always_ff @(posedge clk) begin
		if (accept) begin
			err_q  <= err_in;
			walk_q <= walk;
			sum_q  <= SW'(total_q - pos_q);
			rem_q  <= {{(64 - ERR_W){err_total_q[ERR_W-1]}}, err_total_q};
			frac_q <= '0;
			eq_q   <= '0;
		end
		if (data_vld_s1) begin
			sum_q <= sum_q + SW'(st_rd_data.count);
			rem_q <= rem_q - {{(64 - ERR_W){st_rd_data.err[ERR_W-1]}}, st_rd_data.err};
		end
		if (state_q == S_GDF && div_stat.done) begin
			frac_q <= frac_res;
			neg_q  <= rem_q[63];
		end
		if (state_q == S_GDE && div_stat.done) begin
			eq_q <= eq_res;
		end
		if (state_q == S_GOUT && out_free) begin
			fraction   <= frac_q;
			equity_out <= eq_q;
			more       <= cursor_nx <= CW'(mb);
		end
	end

	assign in_stall = (state_q != S_IDLE);

	whist_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	whist_store #(
		.DEPTH (BINS)
	) u_store (
		.clk     (clk),
		.rd_en   (st_rd_en),
		.rd_addr (st_rd_addr),
		.rd_data (st_rd_data),
		.wr_en   (st_wr_en),
		.wr_addr (st_wr_addr),
		.wr_data (st_wr_data)
	);
endmodule
`default_nettype wire

>>> rtl/whist_div.sv
// Shared restoring divider: 64-bit numerator over 32-bit divisor, one bit a cycle.
// Depends on whist_pkg.
`default_nettype none
module whist_div import whist_pkg::*; (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     start,
	input  wire [DIV_NW-1:0]        num,
	input  wire [DIV_DW-1:0]        den,
	output whist_div_stat_t         stat,
	output logic [DIV_NW-1:0]       quo
);
	localparam int CW = $clog2(DIV_NW + 1);

	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] nq_q;
	logic [DIV_DW:0]   trial;
	logic              fits;

	// shift in the next numerator bit and try the subtraction
	always_comb begin
		trial = {rem_q[DIV_DW-1:0], nq_q[DIV_NW-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_NW - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			nq_q  <= num;
		end else if (busy_q) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			nq_q  <= {nq_q[DIV_NW-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = nq_q;
endmodule
`default_nettype wire

>>> rtl/whist_store.sv
// Bin store: one memory of count and error entries, one write and one registered read port.
// Depends on whist_pkg.
`default_nettype none
module whist_store import whist_pkg::*; #(
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       rd_en,
	input  wire [$clog2(DEPTH)-1:0]   rd_addr,
	output whist_entry_t              rd_data,
	input  wire                       wr_en,
	input  wire [$clog2(DEPTH)-1:0]   wr_addr,
	input  whist_entry_t              wr_data
);
	whist_entry_t mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
`default_nettype wire

>>> rtl/whist_checker.sv
// Port-level checks for the weighted cumulative histogram, bound to the top level.
// Depends on weighted_cumulative_histogram.
`default_nettype none
module whist_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [16:0] fraction,
	input wire [31:0] equity_out,
	input wire        more
);
	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fraction) && $stable(equity_out) &&
		$stable(more))
		else $error("stalled result changed");

	// fraction never exceeds one
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fraction <= 17'h10000)
		else $error("fraction above one");

	// a new result only follows a busy cycle
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without transaction in flight");

	// store clear keeps input stalled straight after reset
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_stall)
		else $error("input taken during store clear");
endmodule

bind weighted_cumulative_histogram whist_checker u_whist_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.fraction   (fraction),
	.equity_out (equity_out),
	.more       (more)
);
`default_nettype wire

>>> tb/sv/weighted_cumulative_histogram_tb.sv
// Self-checking testbench for weighted_cumulative_histogram: directed and random add, rewind,
// unused-code and get-next transactions against a behavioural predictor of the histogram walk.
// Depends on whist_pkg and the RTL of the block.
`default_nettype none
module weighted_cumulative_histogram_tb;
	import whist_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NBINS = 256;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic CFG_STEP = 1'b0;
	localparam logic CFG_MAXBIN = 1'b1;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] diff;
		logic [31:0] err;
	} hist_op_t;

	typedef struct packed {
		logic [16:0] frac;
		logic [31:0] equity;
		logic        more;
	} cum_point_t;

	logic        clk, arst_n;
	logic        in_valid, in_stall;
	logic [1:0]  command;
	logic [31:0] diff_value, error_value;
	logic        out_valid, out_stall;
	logic [16:0] fraction;
	logic [31:0] equity_out;
	logic        more;
	logic        cfg_we, cfg_index;
	logic [31:0] cfg_data;

	weighted_cumulative_histogram #(.BINS(NBINS)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .diff_value(diff_value), .error_value(error_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.fraction(fraction), .equity_out(equity_out), .more(more),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [31:0] m_step;
	logic [7:0]  m_maxbin;
	logic [31:0] m_total, m_positive;
	logic [47:0] m_err_total;
	logic [31:0] m_counts [NBINS];
	logic [47:0] m_errs [NBINS];
	logic [8:0]  m_cursor;

	hist_op_t   pending_ops [$];
	cum_point_t expected_points [$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         seq_hold = 0;
	bit         all_sent = 0;
	bit         sender_hold = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic logic [31:0] sat_inc(logic [31:0] c);
		return (c == CNT_MAX) ? c : c + 1;
	endfunction

	// update the histogram and return whether a point is produced
	function automatic bit histogram_apply(hist_op_t op, output cum_point_t pt);
		logic [7:0]  last;
		logic [31:0] idx;
		logic [47:0] ext;
		logic [63:0] sum, frac;
		longint      rem, eq;
		pt = '0;
		last = m_maxbin;
		case (op.cmd)
			CMD_ADD: begin
				m_total = sat_inc(m_total);
				if (op.diff != 0) begin
					m_positive = sat_inc(m_positive);
					ext = {{16{op.err[31]}}, op.err};
					m_err_total = m_err_total + ext;
					idx = (m_step == 0) ? 32'(last) : op.diff / m_step;
					if (idx > 32'(last)) idx = 32'(last);
					m_counts[idx[7:0]] = sat_inc(m_counts[idx[7:0]]);
					m_errs[idx[7:0]] = m_errs[idx[7:0]] + ext;
				end
				return 0;
			end
			CMD_REWIND: begin
				m_cursor = 0;
				return 0;
			end
			CMD_GET: begin
				if (m_positive != 0 && m_total != 0) begin
					sum = 64'(m_total - m_positive);
					rem = longint'($signed(m_err_total));
					for (int i = 0; i <= ((m_cursor > last) ? last : m_cursor); i++) begin
						sum += 64'(m_counts[i]);
						rem -= longint'($signed(m_errs[i]));
					end
					if (sum > 64'(m_total)) sum = 64'(m_total);
					frac = (sum << 16) / 64'(m_total);
					if (frac > 65536) frac = 65536;
					eq = rem / longint'(m_total);
					if (eq > 64'sd2147483647) eq = 64'sd2147483647;
					if (eq < -64'sd2147483648) eq = -64'sd2147483648;
					pt.frac = frac[16:0];
					pt.equity = eq[31:0];
				end
				if (m_cursor <= last) m_cursor++;
				pt.more = (m_cursor <= last);
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	function automatic hist_op_t rand_add(int mode);
		hist_op_t op;
		op.cmd = CMD_ADD;
		case (mode)
			0: op.diff = 0;
			1: op.diff = $urandom;
			default: op.diff = $urandom_range(1, 300) * m_step / 8 + $urandom_range(0, 3);
		endcase
		op.err = $urandom;
		if ($urandom_range(0, 3) == 0) op.err = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
		return op;
	endfunction

	task automatic push_op(logic [1:0] c, logic [31:0] d, logic [31:0] e);
		hist_op_t op;
		op.cmd = c; op.diff = d; op.err = e;
		pending_ops.push_back(op);
	endtask

	task automatic wait_drained();
		while (pending_ops.size() != 0 || in_valid || expected_points.size() != 0)
			@(posedge clk);
		repeat (450) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [31:0] val);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == CFG_STEP) m_step = val; else m_maxbin = val[7:0];
		@(posedge clk);
	endtask

	// stimulus: phases of configuration, each followed by sequences of items
	initial begin
		logic [31:0] steps [5];
		logic [7:0]  maxes [5];
		int n;
		steps = '{32'h0001_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0, 32'h0000_4000};
		maxes = '{8'd255, 8'd0, 8'd3, 8'd255, 8'd17};
		arst_n = 0; in_valid = 0; command = 0; diff_value = 0; error_value = 0;
		out_stall = 0; cfg_we = 0; cfg_index = 0; cfg_data = 0;
		m_step = 32'h10000; m_maxbin = 8'd255; m_total = 0; m_positive = 0;
		m_err_total = 0; m_cursor = 0;
		for (int i = 0; i < NBINS; i++) begin
			m_counts[i] = 0; m_errs[i] = 0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: no samples, extremes, unused code, rewind
		push_op(CMD_GET, 0, 0);
		push_op(CMD_ADD, 0, 32'h8000_0000);
		push_op(CMD_GET, 0, 0);
		push_op(CMD_ADD, 32'hffff_ffff, 32'h7fff_ffff);
		push_op(CMD_ADD, 32'h0000_0001, 32'h8000_0000);
		push_op(CMD_ADD, 32'h0001_0000, 32'hffff_ffff);
		push_op(CMD_ADD, 32'h0002_8000, 32'h0001_0000);
		push_op(CMD_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
		repeat (4) push_op(CMD_GET, 0, 0);
		push_op(CMD_REWIND, 32'hffff_ffff, 32'hffff_ffff);
		push_op(CMD_GET, 0, 0);
		wait_drained();

		// random phases over several register settings
		for (int ph = 0; ph < 5; ph++) begin
			write_reg(CFG_STEP, steps[ph]);
			write_reg(CFG_MAXBIN, maxes[ph]);
			n = 0;
			while (n < 205) begin
				int r;
				r = $urandom_range(0, 99);
				if (r < 70) begin
					pending_ops.push_back(rand_add(r < 5 ? 0 : (r < 15 ? 1 : 2)));
				end else if (r < 74) begin
					push_op(CMD_REWIND, $urandom, $urandom);
				end else if (r < 76) begin
					push_op(CMD_UNUSED, $urandom, $urandom);
				end else begin
					// short walks keep readouts cheap; occasionally a long run
					int k;
					k = (r == 99) ? $urandom_range(20, 40) : $urandom_range(1, 3);
					push_op(CMD_REWIND, $urandom, $urandom);
					repeat (k) push_op(CMD_GET, $urandom, $urandom);
					n += k;
				end
				n++;
			end
			if (ph == 2) begin
				// hold the sender until all results are back
				while (pending_ops.size() != 0 || in_valid) @(posedge clk);
				sender_hold = 1;
				while (expected_points.size() != 0) @(posedge clk);
				sender_hold = 0;
			end
			wait_drained();
		end
		all_sent = 1;
	end

	// driver
	always @(posedge clk) begin
		cum_point_t pt;
		if (in_valid && !in_stall) begin
			if (histogram_apply({command, diff_value, error_value}, pt))
				expected_points.push_back(pt);
		end
		if (!in_valid || !in_stall) begin
			if (seq_hold > 0) begin
				seq_hold <= seq_hold - 1;
				in_valid <= 0;
			end else if (pending_ops.size() != 0 && !sender_hold && arst_n) begin
				hist_op_t op;
				op = pending_ops.pop_front();
				in_valid <= 1;
				command <= op.cmd;
				diff_value <= op.diff;
				error_value <= op.err;
				seq_hold <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
			end else begin
				in_valid <= 0;
			end
		end
	end

	// monitor
	int stall_left = 0;
	always @(posedge clk) begin
		cum_point_t exp_pt;
		if (out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result f=%h e=%h m=%b",
					fraction, equity_out, more);
			end else begin
				exp_pt = expected_points.pop_front();
				if (fraction !== exp_pt.frac || equity_out !== exp_pt.equity ||
				    more !== exp_pt.more) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected f=%h e=%h m=%b, got f=%h e=%h m=%b",
							exp_pt.frac, exp_pt.equity, exp_pt.more,
							fraction, equity_out, more);
				end
			end
			stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || all_sent || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else if (all_sent) begin
			if (mismatches == 0 && expected_points.size() == 0)
				$display("Testbench completed without errors");
			else
				$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end
endmodule
`default_nettype wire
